// File: hw/rtl/tbc_pkg.sv
// shared types, constants and helpers for the rotated-key tea cipher
`default_nettype none

package tbc_pkg;

  localparam int TBC_ROUNDS = 32;
  localparam logic [31:0] TBC_DELTA = 32'h9E3779B9;

  typedef struct packed {
    logic        cmd;
    logic [31:0] v0;
    logic [31:0] v1;
    logic        last;
  } blk_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } keys_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  // delta times n, wrapped to 32 bits
  function automatic logic [31:0] sum_at(input int n);
    logic [63:0] prod;
    prod = 64'(TBC_DELTA) * 64'(n);
    return prod[31:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbc_ifs.sv
// handshake channels of the cipher block: input blocks, results, key writes
`default_nettype none

interface tbc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] word_low;
  logic [31:0] word_high;
  logic        last_block;

  modport source (output valid, cmd, word_low, word_high, last_block, input ready);
  modport sink (input valid, cmd, word_low, word_high, last_block, output ready);
endinterface

interface tbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_low;
  logic [31:0] result_high;
  logic        last_out;

  modport source (output valid, result_low, result_high, last_out, input ready);
  modport sink (input valid, result_low, result_high, last_out, output ready);
endinterface

interface tbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tea_block_cipher_rotated_key.sv
// top level of the rotated-key tea cipher, ecb, one 64-bit block per transfer
//
// channels: request takes cmd (0 encrypt, 1 decrypt), word_low, word_high
// and last_block; response gives result_low, result_high and last_out.
// cfg writes the 32-bit base key; subkeys are its rotations by 8, 16, 24.
// write the key only while no block is in flight.
// a block passes a chain of 2*ROUNDS half-round cells, one cell per cycle
// while the chain is not stalled, so the 2*ROUNDS cell registers lie
// between the request transfer and response valid.
// a new block enters every cycle unless the chain is stalled: one block
// per cycle sustained, set by the one register stage in each cell.
// the last cell's register is the response register. when the receiver
// stalls, blocks pack up behind it cell by cell; request ready drops only
// once every cell holds a block.
// reset clears all cell valid bits and the key to zero.
`default_nettype none

module tea_block_cipher_rotated_key
  import tbc_pkg::*;
#(
  parameter int ROUNDS = TBC_ROUNDS
) (
  input wire logic clk,
  input wire logic rst,
  tbc_in_if.sink   request,
  tbc_out_if.source response,
  tbc_cfg_if.sink  cfg
);

  localparam int STEPS = 2 * ROUNDS;

  logic [31:0] base_key;
  keys_t       keys;
  logic        valid [STEPS+1];
  logic        ready [STEPS+1];
  blk_t        blk   [STEPS+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_key <= '0;
    end else if (cfg.valid) begin
      base_key <= cfg.data;
    end
  end

  assign keys.k0 = base_key;
  assign keys.k1 = {base_key[23:0], base_key[31:24]};
  assign keys.k2 = {base_key[15:0], base_key[31:16]};
  assign keys.k3 = {base_key[7:0], base_key[31:8]};

  assign valid[0]     = request.valid;
  assign request.ready = ready[0];
  assign blk[0].cmd   = request.cmd;
  assign blk[0].v0    = request.word_low;
  assign blk[0].v1    = request.word_high;
  assign blk[0].last  = request.last_block;

  for (genvar s = 0; s < STEPS; s++) begin : g_cell
    tbc_cell #(
      .ROUNDS (ROUNDS),
      .STEP   (s)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .keys       (keys),
      .prev_valid (valid[s]),
      .prev_ready (ready[s]),
      .prev_blk   (blk[s]),
      .next_valid (valid[s+1]),
      .next_ready (ready[s+1]),
      .next_blk   (blk[s+1])
    );
  end

  assign response.valid       = valid[STEPS];
  assign ready[STEPS]         = response.ready;
  assign response.result_low  = blk[STEPS].v0;
  assign response.result_high = blk[STEPS].v1;
  assign response.last_out    = blk[STEPS].last;

endmodule

`default_nettype wire

// File: hw/rtl/tbc_cell.sv
// one half-round cell of the cipher chain, with its own stage register
`default_nettype none

module tbc_cell
  import tbc_pkg::*;
#(
  parameter int ROUNDS = TBC_ROUNDS,
  parameter int STEP   = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire keys_t keys,
  input  wire logic  prev_valid,
  output logic       prev_ready,
  input  wire blk_t  prev_blk,
  output logic       next_valid,
  input  wire logic  next_ready,
  output blk_t       next_blk
);

  localparam int ROUND = STEP / 2;
  localparam int HALF  = STEP % 2;
  localparam logic [31:0] SUM_ENC = sum_at(ROUND + 1);
  localparam logic [31:0] SUM_DEC = sum_at(ROUNDS - ROUND);

  logic        upd_hi;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] sum;
  logic [31:0] mixed;
  logic [31:0] dst_new;
  blk_t        blk_next;

  always_comb begin
    // decrypt runs each round with the halves swapped
    if (prev_blk.cmd == CMD_DECRYPT) begin
      upd_hi = (HALF == 0);
      sum    = SUM_DEC;
    end else begin
      upd_hi = (HALF == 1);
      sum    = SUM_ENC;
    end
    src = upd_hi ? prev_blk.v0 : prev_blk.v1;
    dst = upd_hi ? prev_blk.v1 : prev_blk.v0;
    ka  = upd_hi ? keys.k2 : keys.k0;
    kb  = upd_hi ? keys.k3 : keys.k1;
    mixed = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    dst_new = (prev_blk.cmd == CMD_DECRYPT) ? dst - mixed : dst + mixed;
    blk_next = prev_blk;
    if (upd_hi) begin
      blk_next.v1 = dst_new;
    end else begin
      blk_next.v0 = dst_new;
    end
  end

  assign prev_ready = !next_valid || next_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_valid <= 1'b0;
    end else if (prev_ready) begin
      next_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_ready && prev_valid) begin
      next_blk <= blk_next;
    end
  end

endmodule

`default_nettype wire
